/* src/srat_pkg.sv */
// Shared types and constants for the section region address translator.
// Holds the region table size, operation and register codes, and the
// packed transaction types. No dependencies.
package srat_pkg;

  // Region table size and derived widths
  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  // Configuration register widths and reset values
  localparam int SC_W              = 5;
  localparam int AL_W              = 5;
  localparam logic [AL_W-1:0] ALIGN_RESET = 5'd12;

  // Configuration register indexes (byte address bit 2)
  localparam logic REG_SECTION_COUNT = 1'b0;
  localparam logic REG_ALIGNMENT     = 1'b1;

  // Operation codes
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_TRANSLATE = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic [31:0] region_start;
    logic [31:0] mapped_size;
    logic [31:0] stored_size;
    logic [31:0] backing_base;
    logic [31:0] query_address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  region_index;
    logic [32:0] backing_offset;
    logic [31:0] next_free_address;
  } out_t;

  // One region table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] span;
    logic [31:0] base;
  } entry_t;

endpackage

/* src/section_region_address_translator_top.sv */
// Top level of the section region address translator: APB registers,
// lookup sequencer with one shared range comparator, output register.
// Depends on srat_pkg and srat_region_mem.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | srat_pkg::in_t
//   out_    | output    | out_valid / out_stall| srat_pkg::out_t
//   APB     | input     | psel/penable/pwrite  | two 5-bit registers
//
// Write or unused op goes straight to finish. Query scans n entries and rounds,
// n = min(section_count, 16); translate scans to the first hit and adds the offset.
// The scan reads one entry per cycle through the single comparator.
// Reset (rst_n low, synchronous) sets section_count 0 and alignment_log2 12;
// the table is not cleared. in_stall is high while an item is in work; a result
// stalled in the output register holds only the following result back.
module section_region_address_translator_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  srat_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output srat_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import srat_pkg::*;

  localparam int CMP_W = CNT_W + SC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OFFSET,
    ST_ROUND,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [SC_W-1:0]   section_count_r, section_count_nxt;
  logic [AL_W-1:0]   align_r, align_nxt;
  logic [IDX_W-1:0]  chk_r, chk_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [31:0]       qa_r, qa_nxt;
  logic [31:0]       hi_r, hi_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic [31:0]       base_r, base_nxt;
  out_t              res_r, res_nxt;
  out_t              out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              cfg_wr;
  logic [CNT_W-1:0]  n_sat;
  logic              in_acc;
  logic              mem_wr_en;
  entry_t            mem_wr_data;
  logic [IDX_W-1:0]  mem_rd_addr;
  entry_t            mem_rd_data;
  logic [31:0]       end_addr;
  logic              in_range;
  logic              last_entry;
  logic [31:0]       align_mask;
  logic [32:0]       round_sum;

  srat_region_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (IDX_W'(in_data.entry_index)),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_ALIGNMENT) ? 32'(align_r) : 32'(section_count_r);

  // searched entry count, saturated to the table size
  assign n_sat = (CMP_W'(section_count_r) > CMP_W'(MAX_REGIONS)) ?
                 CNT_W'(MAX_REGIONS) : CNT_W'(section_count_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // write data: span is the larger of the two sizes
  assign mem_wr_data.start = in_data.region_start;
  assign mem_wr_data.span  = (in_data.mapped_size > in_data.stored_size) ?
                             in_data.mapped_size : in_data.stored_size;
  assign mem_wr_data.base  = in_data.backing_base;
  assign mem_wr_en = in_acc && (in_data.op == OP_WRITE) &&
                     (32'(in_data.entry_index) < 32'(MAX_REGIONS));

  // shared range unit
  assign end_addr   = mem_rd_data.start + mem_rd_data.span;
  assign in_range   = (qa_r >= mem_rd_data.start) && (qa_r < end_addr);
  assign last_entry = ((CNT_W'(chk_r) + CNT_W'(1)) == n_r);

  // rounding
  assign align_mask = (32'd1 << align_r) - 32'd1;
  assign round_sum  = {1'b0, hi_r} + {1'b0, align_mask};

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    section_count_nxt = section_count_r;
    align_nxt         = align_r;
    chk_nxt           = chk_r;
    n_nxt             = n_r;
    op_nxt            = op_r;
    qa_nxt            = qa_r;
    hi_nxt            = hi_r;
    diff_nxt          = diff_r;
    base_nxt          = base_r;
    res_nxt           = res_r;
    out_data_nxt      = out_data_r;
    out_valid_nxt     = out_valid_r;
    mem_rd_addr       = IDX_W'(chk_r + 1'b1);

    if (cfg_wr) begin
      if (paddr[2] == REG_ALIGNMENT) begin
        align_nxt = pwdata[AL_W-1:0];
      end else begin
        section_count_nxt = pwdata[SC_W-1:0];
      end
    end

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        mem_rd_addr = '0;
        if (in_acc) begin
          op_nxt  = in_data.op;
          qa_nxt  = in_data.query_address;
          res_nxt = '0;
          hi_nxt  = '0;
          chk_nxt = '0;
          n_nxt   = n_sat;
          if ((in_data.op == OP_TRANSLATE || in_data.op == OP_QUERY) &&
              (n_sat != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_SCAN: begin
        if (op_r == OP_TRANSLATE) begin
          if (in_range) begin
            diff_nxt             = qa_r - mem_rd_data.start;
            base_nxt             = mem_rd_data.base;
            res_nxt.region_index = 4'(chk_r);
            state_nxt            = ST_OFFSET;
          end else if (last_entry) begin
            state_nxt = ST_FINISH;
          end else begin
            chk_nxt = IDX_W'(chk_r + 1'b1);
          end
        end else begin
          if (end_addr > hi_r) begin
            hi_nxt = end_addr;
          end
          if (last_entry) begin
            state_nxt = ST_ROUND;
          end else begin
            chk_nxt = IDX_W'(chk_r + 1'b1);
          end
        end
      end

      ST_OFFSET: begin
        res_nxt.hit            = 1'b1;
        res_nxt.backing_offset = {1'b0, base_r} + {1'b0, diff_r};
        state_nxt              = ST_FINISH;
      end

      ST_ROUND: begin
        res_nxt.next_free_address = round_sum[31:0] & ~align_mask;
        state_nxt                 = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      section_count_r <= '0;
      align_r         <= ALIGN_RESET;
      out_valid_r     <= 1'b0;
      chk_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      section_count_r <= section_count_nxt;
      align_r         <= align_nxt;
      out_valid_r     <= out_valid_nxt;
      chk_r           <= chk_nxt;
    end
    n_r        <= n_nxt;
    op_r       <= op_nxt;
    qa_r       <= qa_nxt;
    hi_r       <= hi_nxt;
    diff_r     <= diff_nxt;
    base_r     <= base_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // scan pointer never passes the searched entry count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(chk_r) < n_r))
    else $error("scan pointer beyond searched entries");

  // a hit never carries a next-free address
  a_hit_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hit) |-> (out_data_r.next_free_address == '0))
    else $error("hit result carries next free address");

  // a miss reports no index and no offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit) |->
    (out_data_r.region_index == '0 && out_data_r.backing_offset == '0))
    else $error("miss result carries index or offset");

  // a finished transaction never overwrites a result still stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && out_stall) |=> (state_r == ST_FINISH))
    else $error("result issued over a stalled output");

endmodule

/* src/srat_region_mem.sv */
// Region table storage: one write port, one read port, registered read data.
// Depends on srat_pkg for the entry type and table depth.
module srat_region_mem (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [srat_pkg::IDX_W-1:0] wr_addr,
  input  srat_pkg::entry_t        wr_data,
  input  logic [srat_pkg::IDX_W-1:0] rd_addr,
  output srat_pkg::entry_t        rd_data
);
  import srat_pkg::*;

  entry_t mem [MAX_REGIONS];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* bench/section_region_address_translator_top_tb.sv */
// Self-checking testbench for section_region_address_translator_top: sends region
// writes, translations and next-free queries, predicts every result and checks it.
// Depends on srat_pkg and the translator RTL.
`timescale 1ns / 1ps

module section_region_address_translator_top_tb;
  import srat_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;
  localparam int SEGMENT_ITEMS  = 160;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int idle_pct       = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Shadow copy of the region table and registers
  logic [31:0]     model_start [MAX_REGIONS];
  logic [31:0]     model_span  [MAX_REGIONS];
  logic [31:0]     model_base  [MAX_REGIONS];
  logic [SC_W-1:0] model_count;
  logic [AL_W-1:0] model_align;
  out_t            expected_results [$];

  section_region_address_translator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predict the result of one transaction and update the shadow table
  function automatic out_t predict_translation(input in_t t);
    out_t        r;
    int          n;
    int          i;
    logic [31:0] end_addr;
    logic [31:0] top;
    logic [31:0] diff;
    logic [63:0] align;
    logic [63:0] rounded;
    r = '0;
    n = (model_count > MAX_REGIONS) ? MAX_REGIONS : int'(model_count);
    case (t.op)
      OP_WRITE: begin
        model_start[t.entry_index] = t.region_start;
        model_span[t.entry_index]  = (t.mapped_size > t.stored_size) ?
                                     t.mapped_size : t.stored_size;
        model_base[t.entry_index]  = t.backing_base;
      end
      OP_TRANSLATE: begin
        // first containing region in index order wins
        for (i = 0; i < n; i++) begin
          end_addr = model_start[i] + model_span[i];
          if (t.query_address >= model_start[i] && t.query_address < end_addr) begin
            diff             = t.query_address - model_start[i];
            r.hit            = 1'b1;
            r.region_index   = i[3:0];
            r.backing_offset = {1'b0, model_base[i]} + {1'b0, diff};
            break;
          end
        end
      end
      OP_QUERY: begin
        top = '0;
        for (i = 0; i < n; i++) begin
          end_addr = model_start[i] + model_span[i];
          if (end_addr > top) top = end_addr;
        end
        align   = 64'd1 << model_align;
        rounded = ({32'd0, top} + align - 64'd1) & ~(align - 64'd1);
        r.next_free_address = rounded[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [32:0] want,
                               input logic [32:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Result checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, out_data.backing_offset);
      end else begin
        want = expected_results.pop_front();
        if (out_data.hit !== want.hit)
          flag_mismatch("hit", 33'(want.hit), 33'(out_data.hit));
        if (out_data.region_index !== want.region_index)
          flag_mismatch("region_index", 33'(want.region_index),
                        33'(out_data.region_index));
        if (out_data.backing_offset !== want.backing_offset)
          flag_mismatch("backing_offset", want.backing_offset, out_data.backing_offset);
        if (out_data.next_free_address !== want.next_free_address)
          flag_mismatch("next_free_address", 33'(want.next_free_address),
                        33'(out_data.next_free_address));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one transaction; may idle first, or hold off until all results are back
  task automatic send_item(input in_t item);
    int gaps;
    bit hold;
    gaps = 0;
    while (gaps < 200 && $urandom_range(99) < idle_pct) gaps++;
    hold = ($urandom_range(199) == 0);
    if (hold && gaps == 0) gaps = 1;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      if (hold) while (expected_results.size() != 0) @(posedge clk);
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_results.insert(expected_results.size(), predict_translation(item));
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access phase
  task automatic write_register(input logic reg_sel, input logic [4:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_SECTION_COUNT) model_count = value;
    else model_align = value;
  endtask

  task automatic set_config(input logic [4:0] count, input logic [4:0] align);
    wait_for_idle();
    write_register(REG_SECTION_COUNT, count);
    write_register(REG_ALIGNMENT, align);
  endtask

  // Transaction builders; unused fields carry random noise
  function automatic in_t noise_item();
    in_t t;
    t.op            = 2'($urandom_range(3));
    t.entry_index   = 4'($urandom_range(15));
    t.region_start  = $urandom;
    t.mapped_size   = $urandom;
    t.stored_size   = $urandom;
    t.backing_base  = $urandom;
    t.query_address = $urandom;
    return t;
  endfunction

  function automatic in_t region_write(input logic [3:0] idx, input logic [31:0] start,
                                       input logic [31:0] vsize, input logic [31:0] rsize,
                                       input logic [31:0] base);
    in_t t;
    t              = noise_item();
    t.op           = OP_WRITE;
    t.entry_index  = idx;
    t.region_start = start;
    t.mapped_size  = vsize;
    t.stored_size  = rsize;
    t.backing_base = base;
    return t;
  endfunction

  function automatic in_t translate_item(input logic [31:0] addr);
    in_t t;
    t               = noise_item();
    t.op            = OP_TRANSLATE;
    t.query_address = addr;
    return t;
  endfunction

  function automatic in_t query_item();
    in_t t;
    t    = noise_item();
    t.op = OP_QUERY;
    return t;
  endfunction

  // Mostly small sizes so regions sit close together and overlap
  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(32'h4000);
    endcase
  endfunction

  function automatic in_t random_region(input logic [3:0] idx);
    logic [31:0] start;
    case ($urandom_range(9))
      0:       start = $urandom;
      1:       start = 32'hFFFF_0000 | $urandom_range(32'hFFFF);
      2:       start = '0;
      default: start = $urandom_range(32'h000F_FFFF);
    endcase
    return region_write(idx, start, pick_size(), pick_size(), $urandom);
  endfunction

  // Address aimed inside, at the edges of, or away from a written region
  function automatic logic [31:0] aimed_address();
    logic [3:0]  k;
    logic [31:0] s;
    logic [31:0] w;
    k = 4'($urandom_range(15));
    s = model_start[k];
    w = model_span[k];
    case ($urandom_range(9))
      0:       return s + w;
      1:       return s - 32'd1;
      2:       return $urandom;
      default: return (w == 0) ? s : s + $urandom_range(w - 32'd1);
    endcase
  endfunction

  // Empty table: query, miss, and the unused op with every bit set
  task automatic test_empty_table();
    in_t t;
    send_item(query_item());
    send_item(translate_item($urandom));
    t    = '1;
    t.op = OP_UNUSED;
    send_item(t);
  endtask

  // Region edges: size folding, wrapped end, empty span, overlap priority,
  // carry into bit 32 of the offset, alignment extremes
  task automatic test_region_edges();
    logic [31:0] probes [8] = '{32'h0000_1000, 32'h0000_2FFF, 32'h0000_3000, 32'h0000_1850,
                                32'h0001_2FFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_0000};
    send_item(region_write(4'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0800, 32'h0000_0400));
    send_item(region_write(4'd1, 32'h0001_0000, 32'h0000_0100, 32'h0000_3000, 32'hFFFF_FFFF));
    send_item(region_write(4'd2, 32'hFFFF_F000, 32'h0000_2000, 32'h0000_0000, 32'h1234_5678));
    send_item(region_write(4'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
    send_item(region_write(4'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(region_write(4'd5, 32'h0000_1800, 32'h0000_0100, 32'h0000_0100, 32'h0000_0000));
    set_config(5'd6, ALIGN_RESET);
    foreach (probes[i]) send_item(translate_item(probes[i]));
    send_item(query_item());
    set_config(5'd6, 5'd0);
    send_item(query_item());
    set_config(5'd2, 5'd31);
    send_item(query_item());
    send_item(translate_item(32'h0001_0000));
  endtask

  // Load every entry so any count can be searched afterwards
  task automatic test_fill_table();
    for (int idx = 0; idx < MAX_REGIONS; idx++) send_item(random_region(idx[3:0]));
  endtask

  // Count above the table size searches the whole table
  task automatic test_count_saturation();
    set_config(5'd31, 5'($urandom_range(31)));
    repeat (4) begin
      send_item(translate_item(aimed_address()));
      send_item(query_item());
    end
  endtask

  // Random mix under each idle/stall profile, two register settings per profile
  task automatic test_random_traffic();
    int          idle_set  [4] = '{0, 60, 0, 22};
    int          stall_set [4] = '{0, 0, 60, 22};
    logic [4:0]  counts    [4] = '{5'd16, 5'd31, 5'd0, 5'd16};
    logic [4:0]  aligns    [4] = '{5'd12, 5'd0, 5'd31, 5'd31};
    int          sel;
    in_t         item;
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        if (s == 0) set_config(counts[p], aligns[p]);
        else set_config(5'($urandom_range(1, 16)), 5'($urandom_range(31)));
        idle_pct  = idle_set[p];
        stall_pct = stall_set[p];
        repeat (SEGMENT_ITEMS) begin
          sel = $urandom_range(99);
          if (sel < 15) begin
            item = random_region(4'($urandom_range(15)));
          end else if (sel < 70) begin
            item = translate_item(aimed_address());
          end else if (sel < 92) begin
            item = query_item();
          end else begin
            item    = noise_item();
            item.op = OP_UNUSED;
          end
          send_item(item);
        end
      end
    end
  endtask

  initial begin
    model_count = '0;
    model_align = ALIGN_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_region_edges();
    test_fill_table();
    test_count_saturation();
    test_random_traffic();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/srat_pkg.sv
src/srat_region_mem.sv
src/section_region_address_translator_top.sv
bench/section_region_address_translator_top_tb.sv
